/* rtl/core/srfs_pkg.sv */
// Servo relay fire sequencer package: widths, codes, reset values and scaling
// constants shared by the interfaces, controller, datapath and top level.
// No dependencies.
package srfs_pkg;

    // Field widths
    localparam int ANGLE_W    = 8;
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int INTERVAL_W = 10;
    localparam int FUNC_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 3;

    // Angle limit and pulse width scaling
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
    localparam int PULSE_MAX_US = 2400;
    localparam int US_W = $clog2(PULSE_MAX_US + 1);
    localparam logic [US_W-1:0] PULSE_MIN_US = 12'd500;
    localparam int PWM_PERIOD_US = 20000;

    // angle * 1900 / 180 == angle * 95 / 9; divide by 9 with a reciprocal
    localparam int US_SHIFT   = 19;
    localparam int US_MAGIC_W = 23;
    localparam logic [US_MAGIC_W-1:0] US_MAGIC =
        US_MAGIC_W'((((1 << US_SHIFT) + 8) / 9) * 95);
    localparam int US_PROD_W  = ANGLE_W + US_MAGIC_W;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_HOME  = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_HOME_ANGLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_POSITION_A    = 3'd1;
    localparam logic [IDX_W-1:0] REG_POSITION_B    = 3'd2;
    localparam logic [IDX_W-1:0] REG_COOLDOWN      = 3'd3;
    localparam logic [IDX_W-1:0] REG_RELAY_DELAY1  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RELAY_DELAY2  = 3'd5;
    localparam logic [IDX_W-1:0] REG_STEP_DEGREES  = 3'd6;
    localparam logic [IDX_W-1:0] REG_STEP_INTERVAL = 3'd7;

    // Configuration reset values
    localparam logic [ANGLE_W-1:0]    HOME_ANGLE_RST    = 8'd90;
    localparam logic [ANGLE_W-1:0]    POSITION_A_RST    = 8'd30;
    localparam logic [ANGLE_W-1:0]    POSITION_B_RST    = 8'd150;
    localparam logic [DELAY_W-1:0]    COOLDOWN_RST      = 16'd1000;
    localparam logic [DELAY_W-1:0]    RELAY_DELAY1_RST  = 16'd200;
    localparam logic [DELAY_W-1:0]    RELAY_DELAY2_RST  = 16'd200;
    localparam logic [ANGLE_W-1:0]    STEP_DEGREES_RST  = 8'd2;
    localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST = 10'd10;

    // Sequence phase
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 2'd0,
        PH_MOVE  = 2'd1,
        PH_WAIT1 = 2'd2,
        PH_WAIT2 = 2'd3
    } phase_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PULSE,
        ST_PRODUCT,
        ST_DUTY
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic pulse_en;
        logic prod_en;
        logic load_out;
    } ctrl_cmd_t;

    // Clamp an angle register to the servo range
    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] r;
        r = (a > ANGLE_MAX) ? ANGLE_MAX : a;
        return r;
    endfunction

endpackage

/* rtl/core/srfs_if.sv */
// Valid/ready channel interfaces for sequencer events and results.
// Depends on srfs_pkg for field widths.
interface srfs_in_if;
    logic                           valid;
    logic                           ready;
    logic [srfs_pkg::FUNC_W-1:0]    func;
    logic [srfs_pkg::TIME_W-1:0]    now_ms;
    logic                           dead;

    modport source (output valid, output func, output now_ms, output dead, input ready);
    modport sink   (input valid, input func, input now_ms, input dead, output ready);
endinterface

interface srfs_out_if #(
    parameter int PWM_BITS = 14
);
    logic                           valid;
    logic                           ready;
    logic                           start_accepted;
    logic                           firing;
    logic [srfs_pkg::PHASE_W-1:0]   phase;
    logic                           relay1_on;
    logic                           relay2_on;
    logic [srfs_pkg::ANGLE_W-1:0]   servo_angle;
    logic [PWM_BITS-1:0]            servo_duty;

    modport source (
        output valid, output start_accepted, output firing, output phase,
        output relay1_on, output relay2_on, output servo_angle, output servo_duty,
        input ready
    );
    modport sink (
        input valid, input start_accepted, input firing, input phase,
        input relay1_on, input relay2_on, input servo_angle, input servo_duty,
        output ready
    );
endinterface

/* rtl/core/srfs_ctrl.sv */
// Sequencer controller: accepts one event beat, steps the datapath through
// the duty scaling stages and owns the result valid flag. Depends on srfs_pkg.
module srfs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output srfs_pkg::ctrl_cmd_t cmd
);

    srfs_pkg::ctrl_state_t state_reg;
    srfs_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Advance state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srfs_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = srfs_pkg::ST_PULSE;
            end
            srfs_pkg::ST_PULSE:   state_next = srfs_pkg::ST_PRODUCT;
            srfs_pkg::ST_PRODUCT: state_next = srfs_pkg::ST_DUTY;
            srfs_pkg::ST_DUTY:
            begin
                if (out_free)
                    state_next = srfs_pkg::ST_IDLE;
            end
            default: state_next = srfs_pkg::ST_IDLE;
        endcase
    end

    // Drive commands
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.pulse_en = 1'b0;
        cmd.prod_en  = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            srfs_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            srfs_pkg::ST_PULSE:   cmd.pulse_en = 1'b1;
            srfs_pkg::ST_PRODUCT: cmd.prod_en  = 1'b1;
            srfs_pkg::ST_DUTY:    cmd.load_out = out_free;
            default: ;
        endcase
    end

    // Hold the result until the sink takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srfs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/srfs_dp.sv */
// Sequencer datapath: configuration registers, phase and servo state,
// pulse width and duty scaling stages, result register. Depends on srfs_pkg.
module srfs_dp #(
    parameter int PWM_BITS = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srfs_pkg::ctrl_cmd_t             cmd,
    input  logic                            wr_en,
    input  logic [srfs_pkg::IDX_W-1:0]      wr_index,
    input  logic [srfs_pkg::CFG_W-1:0]      wr_data,
    input  logic [srfs_pkg::FUNC_W-1:0]     func,
    input  logic [srfs_pkg::TIME_W-1:0]     now_ms,
    input  logic                            dead,
    output logic                            start_accepted,
    output logic                            firing,
    output logic [srfs_pkg::PHASE_W-1:0]    phase,
    output logic                            relay1_on,
    output logic                            relay2_on,
    output logic [srfs_pkg::ANGLE_W-1:0]    servo_angle,
    output logic [PWM_BITS-1:0]             servo_duty
);

    localparam int AW = srfs_pkg::ANGLE_W;
    localparam int TW = srfs_pkg::TIME_W;

    // Duty = pulse * (2^PWM_BITS - 1) / period, by an exact reciprocal
    localparam int PROD_W     = srfs_pkg::US_W + PWM_BITS;
    localparam int DUTY_SHIFT = PROD_W + $clog2(srfs_pkg::PWM_PERIOD_US);
    localparam int MUL_W      = PROD_W + 1;
    localparam int DUTY_W     = DUTY_SHIFT + PWM_BITS;
    localparam logic [63:0] DUTY_MAGIC_WIDE =
        ((64'd1 << DUTY_SHIFT) + 64'(srfs_pkg::PWM_PERIOD_US) - 64'd1)
        / 64'(srfs_pkg::PWM_PERIOD_US);
    localparam logic [MUL_W-1:0]    DUTY_MAGIC = DUTY_MAGIC_WIDE[MUL_W-1:0];
    localparam logic [PWM_BITS-1:0] PWM_FULL   = '1;

    localparam logic [1:0] RELAY_OPEN = 2'b00;
    localparam logic [1:0] RELAY_ONE  = 2'b01;
    localparam logic [1:0] RELAY_BOTH = 2'b11;

    // Configuration
    logic [AW-1:0]                       home_angle_reg;
    logic [AW-1:0]                       position_a_reg;
    logic [AW-1:0]                       position_b_reg;
    logic [srfs_pkg::DELAY_W-1:0]        cooldown_reg;
    logic [srfs_pkg::DELAY_W-1:0]        relay_delay1_reg;
    logic [srfs_pkg::DELAY_W-1:0]        relay_delay2_reg;
    logic [AW-1:0]                       step_degrees_reg;
    logic [srfs_pkg::INTERVAL_W-1:0]     step_interval_reg;

    // Sequence state
    srfs_pkg::phase_t  phase_reg, phase_next;
    logic [AW-1:0]     cur_angle_reg, cur_angle_next;
    logic [AW-1:0]     tgt_angle_reg, tgt_angle_next;
    logic [TW-1:0]     last_start_reg, last_start_next;
    logic [TW-1:0]     phase_start_reg, phase_start_next;
    logic [TW-1:0]     last_step_reg, last_step_next;
    logic [1:0]        relay_reg, relay_next;
    logic              accepted_reg, accepted_next;

    // Scaling stages
    logic [srfs_pkg::US_W-1:0]  pulse_reg, pulse_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;

    // Result register
    logic                       res_accepted_reg;
    logic                       res_firing_reg;
    logic [srfs_pkg::PHASE_W-1:0] res_phase_reg;
    logic [1:0]                 res_relay_reg;
    logic [AW-1:0]              res_angle_reg;
    logic [PWM_BITS-1:0]        res_duty_reg, res_duty_next;

    // Ramp and timer terms
    logic [TW-1:0]     step_gap;
    logic [TW-1:0]     phase_gap;
    logic [TW-1:0]     start_gap;
    logic              step_due;
    logic [AW:0]       up_sum;
    logic [AW-1:0]     up_angle;
    logic [AW-1:0]     dn_raw;
    logic [AW-1:0]     dn_angle;
    logic [AW-1:0]     stepped;
    logic              at_target;
    logic              ramp_done;
    logic [srfs_pkg::US_PROD_W-1:0] us_scaled;
    logic [DUTY_W-1:0]  duty_wide;

    assign step_gap  = now_ms - last_step_reg;
    assign phase_gap = now_ms - phase_start_reg;
    assign start_gap = now_ms - last_start_reg;
    assign step_due  = step_gap >= TW'(step_interval_reg);

    // Form one ramp step toward the target
    assign up_sum    = {1'b0, cur_angle_reg} + {1'b0, step_degrees_reg};
    assign up_angle  = (up_sum > {1'b0, tgt_angle_reg}) ? tgt_angle_reg : up_sum[AW-1:0];
    assign dn_raw    = (cur_angle_reg >= step_degrees_reg) ?
                       (cur_angle_reg - step_degrees_reg) : '0;
    assign dn_angle  = (dn_raw < tgt_angle_reg) ? tgt_angle_reg : dn_raw;
    assign stepped   = (cur_angle_reg < tgt_angle_reg) ? up_angle : dn_angle;
    assign at_target = cur_angle_reg == tgt_angle_reg;
    assign ramp_done = at_target || (step_due && (stepped == tgt_angle_reg));

    // Apply one event to the sequence state
    always_comb
    begin
        phase_next       = phase_reg;
        cur_angle_next   = cur_angle_reg;
        tgt_angle_next   = tgt_angle_reg;
        last_start_next  = last_start_reg;
        phase_start_next = phase_start_reg;
        last_step_next   = last_step_reg;
        relay_next       = relay_reg;
        accepted_next    = accepted_reg;
        if (cmd.accept)
        begin
            accepted_next = 1'b0;
            unique case (func)
                srfs_pkg::FUNC_TICK:
                begin
                    unique case (phase_reg)
                        srfs_pkg::PH_MOVE:
                        begin
                            if (!at_target && step_due)
                            begin
                                last_step_next = now_ms;
                                cur_angle_next = stepped;
                            end
                            if (ramp_done)
                            begin
                                relay_next       = RELAY_ONE;
                                phase_next       = srfs_pkg::PH_WAIT1;
                                phase_start_next = now_ms;
                            end
                        end
                        srfs_pkg::PH_WAIT1:
                        begin
                            if (phase_gap >= TW'(relay_delay1_reg))
                            begin
                                relay_next       = RELAY_BOTH;
                                phase_next       = srfs_pkg::PH_WAIT2;
                                phase_start_next = now_ms;
                            end
                        end
                        srfs_pkg::PH_WAIT2:
                        begin
                            if (phase_gap >= TW'(relay_delay2_reg))
                            begin
                                relay_next = RELAY_OPEN;
                                phase_next = srfs_pkg::PH_IDLE;
                            end
                        end
                        srfs_pkg::PH_IDLE: ;
                        default: ;
                    endcase
                end
                srfs_pkg::FUNC_START:
                begin
                    if (!dead && (phase_reg == srfs_pkg::PH_IDLE)
                        && (start_gap >= TW'(cooldown_reg)))
                    begin
                        last_start_next = now_ms;
                        tgt_angle_next  = srfs_pkg::clamp_angle(
                            (cur_angle_reg == position_a_reg) ? position_b_reg
                                                              : position_a_reg);
                        phase_next      = srfs_pkg::PH_MOVE;
                        accepted_next   = 1'b1;
                    end
                end
                srfs_pkg::FUNC_HOME:
                begin
                    phase_next     = srfs_pkg::PH_IDLE;
                    relay_next     = RELAY_OPEN;
                    cur_angle_next = srfs_pkg::clamp_angle(home_angle_reg);
                    tgt_angle_next = srfs_pkg::clamp_angle(home_angle_reg);
                end
                default: ;
            endcase
        end
    end

    // Scale angle to pulse microseconds, then to a duty word
    assign us_scaled  = srfs_pkg::US_PROD_W'(cur_angle_reg)
                      * srfs_pkg::US_PROD_W'(srfs_pkg::US_MAGIC);
    assign pulse_next = srfs_pkg::US_W'(us_scaled >> srfs_pkg::US_SHIFT)
                      + srfs_pkg::PULSE_MIN_US;
    assign prod_next  = PROD_W'(pulse_reg) * PROD_W'(PWM_FULL);
    assign duty_wide  = DUTY_W'(prod_reg) * DUTY_W'(DUTY_MAGIC);
    assign res_duty_next = duty_wide[DUTY_SHIFT +: PWM_BITS];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_angle_reg    <= srfs_pkg::HOME_ANGLE_RST;
            position_a_reg    <= srfs_pkg::POSITION_A_RST;
            position_b_reg    <= srfs_pkg::POSITION_B_RST;
            cooldown_reg      <= srfs_pkg::COOLDOWN_RST;
            relay_delay1_reg  <= srfs_pkg::RELAY_DELAY1_RST;
            relay_delay2_reg  <= srfs_pkg::RELAY_DELAY2_RST;
            step_degrees_reg  <= srfs_pkg::STEP_DEGREES_RST;
            step_interval_reg <= srfs_pkg::STEP_INTERVAL_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                srfs_pkg::REG_HOME_ANGLE:    home_angle_reg    <= wr_data[AW-1:0];
                srfs_pkg::REG_POSITION_A:    position_a_reg    <= wr_data[AW-1:0];
                srfs_pkg::REG_POSITION_B:    position_b_reg    <= wr_data[AW-1:0];
                srfs_pkg::REG_COOLDOWN:      cooldown_reg      <= wr_data;
                srfs_pkg::REG_RELAY_DELAY1:  relay_delay1_reg  <= wr_data;
                srfs_pkg::REG_RELAY_DELAY2:  relay_delay2_reg  <= wr_data;
                srfs_pkg::REG_STEP_DEGREES:  step_degrees_reg  <= wr_data[AW-1:0];
                srfs_pkg::REG_STEP_INTERVAL:
                    step_interval_reg <= wr_data[srfs_pkg::INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= srfs_pkg::PH_IDLE;
            cur_angle_reg   <= srfs_pkg::HOME_ANGLE_RST;
            tgt_angle_reg   <= srfs_pkg::HOME_ANGLE_RST;
            last_start_reg  <= '0;
            phase_start_reg <= '0;
            last_step_reg   <= '0;
            relay_reg       <= RELAY_OPEN;
            accepted_reg    <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            cur_angle_reg   <= cur_angle_next;
            tgt_angle_reg   <= tgt_angle_next;
            last_start_reg  <= last_start_next;
            phase_start_reg <= phase_start_next;
            last_step_reg   <= last_step_next;
            relay_reg       <= relay_next;
            accepted_reg    <= accepted_next;
        end
    end

    // Scaling stages and result register
    always_ff @(posedge clk)
    begin
        if (cmd.pulse_en)
            pulse_reg <= pulse_next;
        if (cmd.prod_en)
            prod_reg <= prod_next;
        if (cmd.load_out)
        begin
            res_accepted_reg <= accepted_reg;
            res_firing_reg   <= phase_reg != srfs_pkg::PH_IDLE;
            res_phase_reg    <= phase_reg;
            res_relay_reg    <= relay_reg;
            res_angle_reg    <= cur_angle_reg;
            res_duty_reg     <= res_duty_next;
        end
    end

    assign start_accepted = res_accepted_reg;
    assign firing         = res_firing_reg;
    assign phase          = res_phase_reg;
    assign relay1_on      = res_relay_reg[0];
    assign relay2_on      = res_relay_reg[1];
    assign servo_angle    = res_angle_reg;
    assign servo_duty     = res_duty_reg;

endmodule

/* rtl/core/servo_relay_fire_sequencer.sv */
// Servo relay fire sequencer top level: controller, datapath and checks.
// Depends on srfs_pkg, srfs_if, srfs_ctrl and srfs_dp.
//
// Each event beat (tick, start request or return home) gives exactly one
// result beat carrying the start flag, phase, relay drives, servo angle and
// PWM duty word after the event. The controller first takes the beat and
// updates the sequence state, then steps the datapath through the pulse
// width multiply, the full-scale product and the reciprocal multiply that
// forms the duty word. Results sit in an output register, so the next
// event is taken while a result still waits; the sequence stalls only when
// a new result is ready and the previous one has not yet been taken.
// Configuration writes should be made while no event is in flight.
module servo_relay_fire_sequencer #(
    parameter int PWM_BITS = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    srfs_in_if.sink                         item,
    srfs_out_if.source                      result,
    input  logic                            wr_en,
    input  logic [srfs_pkg::IDX_W-1:0]      wr_index,
    input  logic [srfs_pkg::CFG_W-1:0]      wr_data
);

    srfs_pkg::ctrl_cmd_t cmd;

    srfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    srfs_dp #(
        .PWM_BITS (PWM_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .func           (item.func),
        .now_ms         (item.now_ms),
        .dead           (item.dead),
        .start_accepted (result.start_accepted),
        .firing         (result.firing),
        .phase          (result.phase),
        .relay1_on      (result.relay1_on),
        .relay2_on      (result.relay2_on),
        .servo_angle    (result.servo_angle),
        .servo_duty     (result.servo_duty)
    );

    // One event in flight at a time
    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("event taken while another is in flight");

    // Relay two closes only with relay one, and never while idle
    a_relay_order: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((!result.relay2_on || result.relay1_on)
            && ((result.phase != srfs_pkg::PH_IDLE)
                || (!result.relay1_on && !result.relay2_on))))
        else $error("relay drive inconsistent with phase");

    // An accepted start always leaves the servo moving
    a_start_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.start_accepted) |->
            (result.firing && (result.phase == srfs_pkg::PH_MOVE)))
        else $error("accepted start without servo move");

endmodule

/* verif/tb.sv */
// Self-checking bench for the servo relay fire sequencer: a directed table,
// then phases of random events, each under its own register settings.
// Depends on srfs_pkg, srfs_if and servo_relay_fire_sequencer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srfs_pkg::*;

    localparam int PWM_BITS = 14;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 155;

    // Kinds of register setting per phase
    localparam int KIND_MIN = 0;
    localparam int KIND_MAX = 1;
    localparam int KIND_NO_STEP = 2;
    localparam int KIND_DEFAULT = 3;

    typedef struct packed {
        logic                   start_accepted;
        logic                   firing;
        phase_t                 phase;
        logic                   relay1_on;
        logic                   relay2_on;
        logic [ANGLE_W-1:0]     servo_angle;
        logic [PWM_BITS-1:0]    servo_duty;
    } fire_status_t;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [TIME_W-1:0]  now_ms;
        logic               dead;
        bit                 typed;
        fire_status_t       want;
    } directed_row_t;

    localparam fire_status_t AT_HOME =
        '{1'b0, 1'b0, PH_IDLE, 1'b0, 1'b0, 8'd90, 14'd1187};
    localparam fire_status_t STARTED_AT_HOME =
        '{1'b1, 1'b1, PH_MOVE, 1'b0, 1'b0, 8'd90, 14'd1187};

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    srfs_in_if item_ch ();
    srfs_out_if #(.PWM_BITS(PWM_BITS)) result_ch ();

    servo_relay_fire_sequencer #(.PWM_BITS(PWM_BITS)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #6 clk = ~clk;

    // Predictor copy of the registers
    logic [ANGLE_W-1:0]    cfg_home, cfg_pos_a, cfg_pos_b, cfg_step;
    logic [DELAY_W-1:0]    cfg_cooldown, cfg_delay1, cfg_delay2;
    logic [INTERVAL_W-1:0] cfg_interval;

    // Predictor copy of the sequence state
    phase_t             seq_phase;
    logic [ANGLE_W-1:0] seq_angle, seq_target;
    logic [TIME_W-1:0]  seq_last_start, seq_phase_since, seq_last_step;
    logic [1:0]         seq_relays;

    fire_status_t  pending_status[$];
    directed_row_t directed_rows[$];
    int            fault_count = 0;
    int            idle_cycles = 0;
    bit            calm_in = 1'b0;
    bit            calm_out = 1'b0;
    logic [TIME_W-1:0] clock_ms;

    function automatic logic [ANGLE_W-1:0] limit_angle(input logic [ANGLE_W-1:0] a);
        return (a > 8'd180) ? 8'd180 : a;
    endfunction

    function automatic void send_home();
        seq_phase = PH_IDLE;
        seq_relays = 2'b00;
        seq_angle = limit_angle(cfg_home);
        seq_target = seq_angle;
    endfunction

    // Apply one event to the predicted state and return the status it reports
    function automatic fire_status_t advance_sequencer(input logic [FUNC_W-1:0] fn,
                                                       input logic [TIME_W-1:0] now,
                                                       input logic dead);
        fire_status_t st;
        logic [TIME_W-1:0] since;
        logic [8:0] nxt;
        bit arrived;
        bit took;
        longint unsigned pulse_us;
        longint unsigned full_scale;
        took = 1'b0;
        case (fn)
            FUNC_TICK:
            begin
                case (seq_phase)
                    PH_MOVE:
                    begin
                        arrived = (seq_angle == seq_target);
                        since = now - seq_last_step;
                        if (!arrived && since >= TIME_W'(cfg_interval))
                        begin
                            seq_last_step = now;
                            if (seq_angle < seq_target)
                            begin
                                nxt = {1'b0, seq_angle} + {1'b0, cfg_step};
                                seq_angle = (nxt > {1'b0, seq_target}) ? seq_target : nxt[7:0];
                            end
                            else
                            begin
                                nxt = (seq_angle >= cfg_step) ? {1'b0, seq_angle - cfg_step} : 9'd0;
                                seq_angle = (nxt < {1'b0, seq_target}) ? seq_target : nxt[7:0];
                            end
                            arrived = (seq_angle == seq_target);
                        end
                        if (arrived)
                        begin
                            seq_relays = 2'b01;
                            seq_phase = PH_WAIT1;
                            seq_phase_since = now;
                        end
                    end
                    PH_WAIT1:
                    begin
                        since = now - seq_phase_since;
                        if (since >= TIME_W'(cfg_delay1))
                        begin
                            seq_relays = 2'b11;
                            seq_phase = PH_WAIT2;
                            seq_phase_since = now;
                        end
                    end
                    PH_WAIT2:
                    begin
                        since = now - seq_phase_since;
                        if (since >= TIME_W'(cfg_delay2))
                        begin
                            seq_relays = 2'b00;
                            seq_phase = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            FUNC_START:
            begin
                since = now - seq_last_start;
                if (!dead && seq_phase == PH_IDLE && since >= TIME_W'(cfg_cooldown))
                begin
                    took = 1'b1;
                    seq_last_start = now;
                    // toggle on the raw register value, clamp only what is taken
                    seq_target = limit_angle((seq_angle == cfg_pos_a) ? cfg_pos_b : cfg_pos_a);
                    seq_phase = PH_MOVE;
                end
            end
            FUNC_HOME:
                send_home();
            default:
            begin
            end
        endcase
        pulse_us = longint'(limit_angle(seq_angle)) * 1900 / 180 + 500;
        full_scale = (64'd1 << PWM_BITS) - 1;
        st.start_accepted = took;
        st.firing = (seq_phase != PH_IDLE);
        st.phase = seq_phase;
        st.relay1_on = seq_relays[0];
        st.relay2_on = seq_relays[1];
        st.servo_angle = seq_angle;
        st.servo_duty = PWM_BITS'((pulse_us * full_scale) / 20000);
        return st;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] fn, input logic [TIME_W-1:0] now,
                           input logic dead, input bit typed, input fire_status_t want);
        directed_row_t row;
        row.func = fn;
        row.now_ms = now;
        row.dead = dead;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // Write one register and mirror it into the predictor
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        case (idx)
            REG_HOME_ANGLE:    cfg_home = val[ANGLE_W-1:0];
            REG_POSITION_A:    cfg_pos_a = val[ANGLE_W-1:0];
            REG_POSITION_B:    cfg_pos_b = val[ANGLE_W-1:0];
            REG_COOLDOWN:      cfg_cooldown = val[DELAY_W-1:0];
            REG_RELAY_DELAY1:  cfg_delay1 = val[DELAY_W-1:0];
            REG_RELAY_DELAY2:  cfg_delay2 = val[DELAY_W-1:0];
            REG_STEP_DEGREES:  cfg_step = val[ANGLE_W-1:0];
            REG_STEP_INTERVAL: cfg_interval = val[INTERVAL_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pick_angle();
        return CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(181, 255)
                                                  : $urandom_range(0, 180));
    endfunction

    // Load one full register set; kind picks extremes, defaults or random
    task automatic load_settings(input int kind);
        logic [CFG_W-1:0] v[8];
        case (kind)
            KIND_MIN:
                v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0};
            KIND_MAX:
                v = '{16'd255, 16'd255, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'd255, 16'd1023};
            KIND_DEFAULT:
                v = '{16'(HOME_ANGLE_RST), 16'(POSITION_A_RST), 16'(POSITION_B_RST),
                      16'(COOLDOWN_RST), 16'(RELAY_DELAY1_RST), 16'(RELAY_DELAY2_RST),
                      16'(STEP_DEGREES_RST), 16'(STEP_INTERVAL_RST)};
            default:
            begin
                v[REG_HOME_ANGLE] = pick_angle();
                v[REG_POSITION_A] = ($urandom_range(0, 3) == 0) ? v[REG_HOME_ANGLE] : pick_angle();
                v[REG_POSITION_B] = ($urandom_range(0, 5) == 0) ? v[REG_POSITION_A] : pick_angle();
                v[REG_COOLDOWN] = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                     : $urandom_range(0, 1500));
                v[REG_RELAY_DELAY1] = CFG_W'(($urandom_range(0, 5) == 0)
                                             ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 400));
                v[REG_RELAY_DELAY2] = CFG_W'(($urandom_range(0, 5) == 0)
                                             ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 400));
                v[REG_STEP_DEGREES] = CFG_W'(($urandom_range(0, 5) == 0)
                                             ? $urandom_range(13, 255)
                                             : $urandom_range(1, 12));
                v[REG_STEP_INTERVAL] = CFG_W'(($urandom_range(0, 4) == 0)
                                              ? $urandom_range(0, 1023)
                                              : $urandom_range(0, 40));
                if (kind == KIND_NO_STEP)
                    v[REG_STEP_DEGREES] = 16'd0;
            end
        endcase
        write_reg(REG_HOME_ANGLE, v[REG_HOME_ANGLE]);
        write_reg(REG_POSITION_A, v[REG_POSITION_A]);
        write_reg(REG_POSITION_B, v[REG_POSITION_B]);
        write_reg(REG_COOLDOWN, v[REG_COOLDOWN]);
        write_reg(REG_RELAY_DELAY1, v[REG_RELAY_DELAY1]);
        write_reg(REG_RELAY_DELAY2, v[REG_RELAY_DELAY2]);
        write_reg(REG_STEP_DEGREES, v[REG_STEP_DEGREES]);
        write_reg(REG_STEP_INTERVAL, v[REG_STEP_INTERVAL]);
        wr_en <= 1'b0;
    endtask

    // Advance the stamp, mostly by amounts that matter for the current settings
    function automatic void next_stamp();
        int unsigned r;
        int unsigned span;
        r = $urandom_range(0, 15);
        span = 32'((cfg_delay1 > cfg_delay2) ? cfg_delay1 : cfg_delay2);
        if (r < 8)
            clock_ms = clock_ms + $urandom_range(0, cfg_interval + 2);
        else if (r < 13)
            clock_ms = clock_ms + $urandom_range(0, span / 3 + 2);
        else if (r == 13)
            clock_ms = clock_ms + $urandom_range(0, cfg_cooldown + 2);
        else if (r == 14)
            clock_ms = $urandom();
    endfunction

    // Offer one event beat, then predict its status once it is taken
    task automatic push_event(input logic [FUNC_W-1:0] fn, input logic [TIME_W-1:0] now,
                              input logic dead, input bit typed, input fire_status_t want);
        int gap;
        fire_status_t pred;
        gap = calm_in ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 39) == 0)
            calm_in = !calm_in;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.func <= fn;
        item_ch.now_ms <= now;
        item_ch.dead <= dead;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        pred = advance_sequencer(fn, now, dead);
        pending_status.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Stall watchdog: any taken beat on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, compare each taken beat with the oldest status
    initial
    begin : result_side
        int gap;
        fire_status_t got;
        fire_status_t want;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = calm_out ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 39) == 0)
                calm_out = !calm_out;
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got.start_accepted = result_ch.start_accepted;
            got.firing = result_ch.firing;
            got.phase = phase_t'(result_ch.phase);
            got.relay1_on = result_ch.relay1_on;
            got.relay2_on = result_ch.relay2_on;
            got.servo_angle = result_ch.servo_angle;
            got.servo_duty = result_ch.servo_duty;
            if (pending_status.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result beat with nothing outstanding: %p", got);
            end
            else
            begin
                want = pending_status.pop_front();
                if (got.start_accepted !== want.start_accepted || got.firing !== want.firing ||
                    got.phase !== want.phase || got.relay1_on !== want.relay1_on ||
                    got.relay2_on !== want.relay2_on || got.servo_angle !== want.servo_angle ||
                    got.servo_duty !== want.servo_duty)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch: want acc=%0d fire=%0d ph=%0d r1=%0d r2=%0d ",
                                  "ang=%0d duty=%0d / got acc=%0d fire=%0d ph=%0d r1=%0d ",
                                  "r2=%0d ang=%0d duty=%0d"},
                                 want.start_accepted, want.firing, want.phase,
                                 want.relay1_on, want.relay2_on, want.servo_angle,
                                 want.servo_duty, got.start_accepted, got.firing, got.phase,
                                 got.relay1_on, got.relay2_on, got.servo_angle,
                                 got.servo_duty);
                end
            end
        end
    end

    // Event side: reset, directed table, then random phases
    initial
    begin : event_side
        int r;
        logic [FUNC_W-1:0] fn;
        logic dead;
        rst_n <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= '0;
        wr_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.func <= FUNC_TICK;
        item_ch.now_ms <= '0;
        item_ch.dead <= 1'b0;

        // Predictor at reset
        cfg_home = HOME_ANGLE_RST;
        cfg_pos_a = POSITION_A_RST;
        cfg_pos_b = POSITION_B_RST;
        cfg_cooldown = COOLDOWN_RST;
        cfg_delay1 = RELAY_DELAY1_RST;
        cfg_delay2 = RELAY_DELAY2_RST;
        cfg_step = STEP_DEGREES_RST;
        cfg_interval = STEP_INTERVAL_RST;
        seq_last_start = '0;
        seq_phase_since = '0;
        seq_last_step = '0;
        send_home();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Refusals, cooldown from time zero, unused code, ramp timing and stamp wrap
        add_row(FUNC_TICK,   32'd0,          1'b0, 1'b1, AT_HOME);
        add_row(FUNC_START,  32'd2000,       1'b1, 1'b1, AT_HOME);
        add_row(FUNC_START,  32'd999,        1'b0, 1'b1, AT_HOME);
        add_row(FUNC_UNUSED, 32'd5,          1'b1, 1'b1, AT_HOME);
        add_row(FUNC_HOME,   32'd7,          1'b0, 1'b1, AT_HOME);
        add_row(FUNC_START,  32'd1000,       1'b0, 1'b1, STARTED_AT_HOME);
        add_row(FUNC_TICK,   32'd1005,       1'b0, 1'b0, AT_HOME);
        add_row(FUNC_TICK,   32'd1014,       1'b1, 1'b0, AT_HOME);
        add_row(FUNC_TICK,   32'd1015,       1'b0, 1'b0, AT_HOME);
        add_row(FUNC_START,  32'd5000,       1'b0, 1'b0, AT_HOME);
        add_row(FUNC_HOME,   32'd5001,       1'b1, 1'b1, AT_HOME);
        add_row(FUNC_START,  32'd5500,       1'b1, 1'b1, AT_HOME);
        add_row(FUNC_START,  32'd5999,       1'b0, 1'b1, STARTED_AT_HOME);
        add_row(FUNC_TICK,   32'hFFFF_FFF0,  1'b0, 1'b0, AT_HOME);
        add_row(FUNC_TICK,   32'hFFFF_FFFF,  1'b1, 1'b0, AT_HOME);
        add_row(FUNC_TICK,   32'h0000_0004,  1'b0, 1'b0, AT_HOME);
        add_row(FUNC_TICK,   32'h0000_0009,  1'b0, 1'b0, AT_HOME);
        add_row(FUNC_TICK,   32'h8000_0000,  1'b0, 1'b0, AT_HOME);
        add_row(FUNC_START,  32'h8000_0001,  1'b0, 1'b0, AT_HOME);
        add_row(FUNC_HOME,   32'hFFFF_FFFF,  1'b0, 1'b1, AT_HOME);
        add_row(FUNC_START,  32'h0000_0000,  1'b0, 1'b0, AT_HOME);
        add_row(FUNC_UNUSED, 32'h5555_AAAA,  1'b0, 1'b0, AT_HOME);
        add_row(FUNC_HOME,   32'h0000_0001,  1'b1, 1'b1, AT_HOME);

        foreach (directed_rows[i])
            push_event(directed_rows[i].func, directed_rows[i].now_ms, directed_rows[i].dead,
                       directed_rows[i].typed, directed_rows[i].want);
        item_ch.valid <= 1'b0;
        clock_ms = 32'd1;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            load_settings(p);
            // start some phases just short of the stamp wrap
            if (p % 2 == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                next_stamp();
                r = $urandom_range(0, 99);
                dead = 1'($urandom_range(0, 1));
                if (seq_phase == PH_IDLE)
                begin
                    if (r < 25)
                    begin
                        fn = FUNC_START;
                        dead = ($urandom_range(0, 7) == 0);
                    end
                    else if (r < 28)
                        fn = FUNC_HOME;
                    else if (r < 30)
                        fn = FUNC_UNUSED;
                    else
                        fn = FUNC_TICK;
                end
                else
                begin
                    if (r < 5)
                        fn = FUNC_START;
                    else if (r < 8)
                        fn = FUNC_HOME;
                    else if (r < 10)
                        fn = FUNC_UNUSED;
                    else
                        fn = FUNC_TICK;
                end
                push_event(fn, clock_ms, dead, 1'b0, AT_HOME);
            end
            item_ch.valid <= 1'b0;
        end

        // Wait out the last results and the pipeline behind them
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_status.size() != 0)
            fault_count++;
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
